// ----- hdl/rdft_pkg.sv -----
// Shared constants, types and the arctangent step table of the real-input DFT block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rdft_pkg;

  localparam int MaxPoints   = 64;
  localparam int AddrW       = $clog2(MaxPoints);
  localparam int CntW        = AddrW + 1;
  localparam int SampleW     = 16;
  localparam int TwW         = 18;
  localparam int ProdW       = SampleW + TwW;
  localparam int AccW        = 40;
  localparam int DivW        = 23;
  localparam int DivCntW     = $clog2(DivW);
  localparam int CordicSteps = 14;
  localparam int CordicStart = 19898;
  localparam int AngleW      = 16;
  localparam int PolW        = 34;
  localparam int RootW       = 32;

  // One twiddle pair, Q2.15 with one = 32768.
  typedef struct packed {
    logic signed [TwW-1:0] cs;
    logic signed [TwW-1:0] sn;
  } tw_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SETUP,
    S_SETUP_WAIT,
    S_TW,
    S_TW_WAIT,
    S_MAC_INIT,
    S_MAC,
    S_DRAIN,
    S_NORM,
    S_NORM_WAIT,
    S_POLAR,
    S_POLAR_WAIT,
    S_EMIT
  } state_e;

  // Arctangent of 2^-i in units of pi/32768.
  function automatic logic [13:0] atan_step(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rdft_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on rdft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdft_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rdft_pkg::DivW-1:0]   dividend_i,
  input  wire logic [rdft_pkg::CntW-1:0]   divisor_i,
  output logic                             done_o,
  output logic [rdft_pkg::DivW-1:0]        quotient_o,
  output logic [rdft_pkg::CntW-1:0]        remainder_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [rdft_pkg::DivCntW-1:0]    cnt_q;
  logic [rdft_pkg::DivW-1:0]       dq_q;
  logic [rdft_pkg::CntW-1:0]       rem_q;
  logic [rdft_pkg::CntW-1:0]       dvs_q;
  logic [rdft_pkg::CntW:0]         trial;
  logic [rdft_pkg::CntW:0]         diff;
  logic                            ge;
  logic                            last_step;

  assign trial     = {rem_q, dq_q[rdft_pkg::DivW-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign diff      = trial - {1'b0, dvs_q};
  assign last_step = cnt_q == rdft_pkg::DivCntW'(rdft_pkg::DivW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Shift the dividend out at the top and the quotient in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[rdft_pkg::DivW-2:0], ge};
      rem_q <= ge ? diff[rdft_pkg::CntW-1:0] : trial[rdft_pkg::CntW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ----- hdl/rdft_twiddle.sv -----
// Iterative CORDIC rotation: turns a 16-bit angle (1/65536 turn) into a cos/sin pair.
// Depends on rdft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdft_twiddle (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rdft_pkg::AngleW-1:0]  angle_i,
  output logic                              done_o,
  output rdft_pkg::tw_t                     tw_o
);

  localparam int ZW = 17;

  logic                           busy_q;
  logic                           done_q;
  logic [3:0]                     i_q;
  logic signed [rdft_pkg::TwW-1:0] x_q, y_q, xf, yf, dx, dy;
  logic signed [ZW-1:0]           z_q;
  logic signed [ZW-1:0]           at;
  logic [1:0]                     quad_q;
  logic                           zero_q;
  logic                           last_step;

  assign last_step = i_q == 4'(rdft_pkg::CordicSteps - 1);
  assign dx        = y_q >>> i_q;
  assign dy        = x_q >>> i_q;
  assign at        = {3'b000, rdft_pkg::atan_step(i_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rdft_pkg::TwW'(rdft_pkg::CordicStart);
      y_q    <= '0;
      z_q    <= {3'b000, angle_i[13:0]};
      quad_q <= angle_i[15:14];
      zero_q <= angle_i[13:0] == 14'd0;
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  // Exact unit vector on quarter-turn multiples, then fold by quadrant.
  always_comb begin
    xf = zero_q ? rdft_pkg::TwW'(32768) : x_q;
    yf = zero_q ? '0 : y_q;
    case (quad_q)
      2'd0: begin
        tw_o.cs = xf;
        tw_o.sn = yf;
      end
      2'd1: begin
        tw_o.cs = -yf;
        tw_o.sn = xf;
      end
      2'd2: begin
        tw_o.cs = -xf;
        tw_o.sn = -yf;
      end
      default: begin
        tw_o.cs = yf;
        tw_o.sn = -xf;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- hdl/rdft_polar.sv -----
// Polar conversion of one bin: rounded integer square root and CORDIC vectoring phase.
// Both run side by side, one step per cycle. Depends on rdft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdft_polar (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [rdft_pkg::SampleW-1:0] re_i,
  input  wire logic signed [rdft_pkg::SampleW-1:0] im_i,
  output logic                                     done_o,
  output logic [rdft_pkg::SampleW-1:0]             mag_o,
  output logic [rdft_pkg::SampleW-1:0]             phase_o
);

  localparam int PW = rdft_pkg::PolW;
  localparam int RW = rdft_pkg::RootW;
  localparam int ZW = 18;

  logic                            busy_q;
  logic                            sq_q;
  logic                            done_q;
  logic [3:0]                      i_q;
  logic signed [rdft_pkg::SampleW-1:0] re_q, im_q;
  logic signed [PW-1:0]            x_q, y_q, dx, dy, re_ext, im_ext;
  logic signed [ZW-1:0]            z_q, at;
  logic [RW-1:0]                   rem_q, res_q, bit_q, trial, res_rnd;
  logic signed [RW-1:0]            re_sq, im_sq;
  logic                            last_step;

  assign last_step = i_q == 4'd15;
  assign dx        = y_q >>> i_q;
  assign dy        = x_q >>> i_q;
  assign at        = {4'b0000, rdft_pkg::atan_step(i_q)};
  assign re_ext    = {{(PW - rdft_pkg::SampleW){re_i[rdft_pkg::SampleW-1]}}, re_i};
  assign im_ext    = {{(PW - rdft_pkg::SampleW){im_i[rdft_pkg::SampleW-1]}}, im_i};
  assign re_sq     = re_q * re_q;
  assign im_sq     = im_q * im_q;
  assign trial     = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sq_q   <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= busy_q && !sq_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        sq_q   <= 1'b1;
        i_q    <= '0;
      end else if (sq_q) begin
        sq_q <= 1'b0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      re_q <= re_i;
      im_q <= im_i;
      // Fold the left half plane by pi before vectoring.
      if (re_i[rdft_pkg::SampleW-1]) begin
        x_q <= (PW'(0) - re_ext) <<< 14;
        y_q <= (PW'(0) - im_ext) <<< 14;
        z_q <= ZW'(32768);
      end else begin
        x_q <= re_ext <<< 14;
        y_q <= im_ext <<< 14;
        z_q <= '0;
      end
    end else if (sq_q) begin
      rem_q <= RW'(re_sq) + RW'(im_sq);
      res_q <= '0;
      bit_q <= RW'(1) << 30;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
      if (i_q < 4'(rdft_pkg::CordicSteps)) begin
        if (y_q > 0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end
      end
    end
  end

  assign res_rnd = (rem_q > res_q) ? res_q + 1'b1 : res_q;
  assign mag_o   = res_rnd[rdft_pkg::SampleW-1:0];

  // Axes and the zero vector bypass the vectoring result.
  always_comb begin
    if (im_q == '0) begin
      phase_o = re_q[rdft_pkg::SampleW-1] ? 16'h8000 : 16'h0000;
    end else if (re_q == '0) begin
      phase_o = im_q[rdft_pkg::SampleW-1] ? 16'hC000 : 16'h4000;
    end else begin
      phase_o = z_q[rdft_pkg::SampleW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- hdl/real_dft_magnitude_phase.sv -----
// Direct DFT of a block of up to 64 real Q11.4 samples, normalized by N, with polar output.
// No new sample is taken until the last bin of the current block has been emitted; the block
// rate is set by the single read port of each memory in the MAC loop and by the serial
// divider and polar unit per bin.
// Reset: asynchronous, active low; clears the sample count, overflow flag and handshakes.
// The sample and twiddle memories are not cleared; only entries written in a block are read.
`timescale 1ns / 1ps
`default_nettype none

module real_dft_magnitude_phase (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_i,
  input  wire logic        last_sample_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       bin_index_o,
  output logic [15:0]      real_part_o,
  output logic [15:0]      imag_part_o,
  output logic [15:0]      magnitude_o,
  output logic [15:0]      phase_o,
  output logic             overflow_o,
  output logic             last_bin_o
);

  localparam int AW = rdft_pkg::AddrW;
  localparam int CW = rdft_pkg::CntW;
  localparam int SW = rdft_pkg::SampleW;
  localparam int PW = rdft_pkg::ProdW;
  localparam int XW = rdft_pkg::AccW;
  localparam int DW = rdft_pkg::DivW;

  // ---------------------------------------------------------------------------
  // Storage: sample memory is written while loading, twiddle memory is built once
  // per block; both are read together in the MAC loop, so accesses never overlap.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] smp_mem [0:rdft_pkg::MaxPoints-1];
  rdft_pkg::tw_t        tw_mem  [0:rdft_pkg::MaxPoints-1];

  rdft_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q;     // samples held
  logic          drop_q;    // a sample of this block was dropped
  logic [CW-1:0] n_q;       // point count of the running transform
  logic [AW-1:0] n_m1;
  logic [AW-1:0] k_q;       // current bin
  logic [AW-1:0] j_q;       // sample index in MAC loop
  logic [AW-1:0] m_q;       // k*j mod N
  logic [CW-1:0] m_sum;
  logic [AW-1:0] mt_q;      // twiddle entry being built
  logic [15:0]   q1_q;      // floor(65536/N) mod 65536
  logic [CW-1:0] r1_q;      // 65536 mod N
  logic [15:0]   ang_q;     // round(m*65536/N) mod 65536
  logic [CW-1:0] ra_q;      // remainder of the angle numerator
  logic [CW:0]   ra_sum;
  logic          ra_wrap;

  logic in_fire, div_start, tw_start, pol_start, mac_init, rd_en, emit, last_k;
  logic store_ok;

  // MAC pipeline
  logic                 rd_v_q, prod_v_q;
  logic signed [SW-1:0] smp_rd_q;
  rdft_pkg::tw_t        tw_rd_q;
  logic signed [PW-1:0] prod_re_q, prod_im_q;
  logic signed [XW-1:0] acc_re_q, acc_im_q;

  // Normalization
  logic [XW-1:0] mag_re, mag_im, u_re, u_im, n_half;
  logic [DW-1:0] div_a_in, v_re, v_im;
  logic          dre_done, dim_done;
  logic [DW-1:0] quo_re, quo_im;
  logic [CW-1:0] rem_re, rem_im;
  logic [SW-1:0] sat_re, sat_im;
  logic signed [SW-1:0] re_q, im_q;

  // Twiddle and polar units
  logic                tw_done;
  rdft_pkg::tw_t       tw_res;
  logic                pol_done;
  logic [SW-1:0]       pol_mag, pol_phase;

  // Output register
  logic          out_valid_q;
  logic [AW-1:0] o_bin_q;
  logic [SW-1:0] o_re_q, o_im_q, o_mag_q, o_ph_q;
  logic          o_ovf_q, o_last_q;

  assign n_m1     = AW'(n_q - 1'b1);
  assign last_k   = k_q == n_m1;
  assign store_ok = cnt_q < CW'(rdft_pkg::MaxPoints);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdft_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    tw_start   = 1'b0;
    pol_start  = 1'b0;
    mac_init   = 1'b0;
    rd_en      = 1'b0;
    emit       = 1'b0;
    case (state_q)
      rdft_pkg::S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i && last_sample_i) begin
          state_d = rdft_pkg::S_SETUP;
        end
      end
      rdft_pkg::S_SETUP: begin
        div_start = 1'b1;
        state_d   = rdft_pkg::S_SETUP_WAIT;
      end
      rdft_pkg::S_SETUP_WAIT: begin
        if (dre_done) begin
          state_d = rdft_pkg::S_TW;
        end
      end
      rdft_pkg::S_TW: begin
        tw_start = 1'b1;
        state_d  = rdft_pkg::S_TW_WAIT;
      end
      rdft_pkg::S_TW_WAIT: begin
        if (tw_done) begin
          state_d = (mt_q == n_m1) ? rdft_pkg::S_MAC_INIT : rdft_pkg::S_TW;
        end
      end
      rdft_pkg::S_MAC_INIT: begin
        mac_init = 1'b1;
        state_d  = rdft_pkg::S_MAC;
      end
      rdft_pkg::S_MAC: begin
        rd_en = 1'b1;
        if (j_q == n_m1) begin
          state_d = rdft_pkg::S_DRAIN;
        end
      end
      rdft_pkg::S_DRAIN: begin
        if (!rd_v_q && !prod_v_q) begin
          state_d = rdft_pkg::S_NORM;
        end
      end
      rdft_pkg::S_NORM: begin
        div_start = 1'b1;
        state_d   = rdft_pkg::S_NORM_WAIT;
      end
      rdft_pkg::S_NORM_WAIT: begin
        if (dre_done) begin
          state_d = rdft_pkg::S_POLAR;
        end
      end
      rdft_pkg::S_POLAR: begin
        pol_start = 1'b1;
        state_d   = rdft_pkg::S_POLAR_WAIT;
      end
      rdft_pkg::S_POLAR_WAIT: begin
        if (pol_done) begin
          state_d = rdft_pkg::S_EMIT;
        end
      end
      rdft_pkg::S_EMIT: begin
        // Hand the bin over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = last_k ? rdft_pkg::S_LOAD : rdft_pkg::S_MAC_INIT;
        end
      end
      default: begin
        state_d = rdft_pkg::S_LOAD;
      end
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Loading: store the word while there is room, otherwise drop it and flag.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire && store_ok) begin
      smp_mem[cnt_q[AW-1:0]] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
      n_q    <= '0;
      k_q    <= '0;
    end else begin
      if (in_fire) begin
        if (store_ok) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          drop_q <= 1'b1;
        end
        if (last_sample_i) begin
          n_q <= store_ok ? cnt_q + 1'b1 : cnt_q;
        end
      end
      if (state_q == rdft_pkg::S_SETUP) begin
        k_q <= '0;
      end
      if (emit) begin
        k_q <= k_q + 1'b1;
        // Empty the store after the final bin.
        if (last_k) begin
          cnt_q  <= '0;
          drop_q <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Twiddle table: angle m -> round(m*65536/N), advanced by 65536/N per entry
  // as quotient plus carried remainder.
  // ---------------------------------------------------------------------------
  assign ra_sum  = {1'b0, ra_q} + {1'b0, r1_q};
  assign ra_wrap = ra_sum >= {1'b0, n_q};

  always_ff @(posedge clk_i) begin
    if (state_q == rdft_pkg::S_SETUP_WAIT && dre_done) begin
      q1_q  <= quo_re[15:0];
      r1_q  <= rem_re;
      ang_q <= '0;
      ra_q  <= n_q >> 1;
      mt_q  <= '0;
    end else if (state_q == rdft_pkg::S_TW_WAIT && tw_done) begin
      tw_mem[mt_q] <= tw_res;
      ang_q        <= ang_q + q1_q + {15'd0, ra_wrap};
      ra_q         <= ra_wrap ? CW'(ra_sum - {1'b0, n_q}) : CW'(ra_sum);
      mt_q         <= mt_q + 1'b1;
    end
  end

  rdft_twiddle u_twiddle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tw_start),
    .angle_i (ang_q),
    .done_o  (tw_done),
    .tw_o    (tw_res)
  );

  // ---------------------------------------------------------------------------
  // MAC loop: read sample j and twiddle (k*j mod N), register the products,
  // then accumulate.
  // ---------------------------------------------------------------------------
  assign m_sum = {1'b0, m_q} + {1'b0, k_q};

  always_ff @(posedge clk_i) begin
    if (mac_init) begin
      j_q <= '0;
      m_q <= '0;
    end else if (rd_en) begin
      j_q <= j_q + 1'b1;
      m_q <= (m_sum >= n_q) ? AW'(m_sum - n_q) : AW'(m_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      smp_rd_q <= smp_mem[j_q];
      tw_rd_q  <= tw_mem[m_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= rd_en;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_re_q <= smp_rd_q * $signed(tw_rd_q.cs);
      prod_im_q <= smp_rd_q * $signed(tw_rd_q.sn);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_init) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (prod_v_q) begin
      acc_re_q <= acc_re_q + {{(XW - PW){prod_re_q[PW-1]}}, prod_re_q};
      acc_im_q <= acc_im_q - {{(XW - PW){prod_im_q[PW-1]}}, prod_im_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Normalization: round(|acc| / (N*32768)) half away from zero. The power of two
  // is a shift; the division by N runs in the serial dividers.
  // ---------------------------------------------------------------------------
  assign mag_re = acc_re_q[XW-1] ? XW'(-acc_re_q) : XW'(acc_re_q);
  assign mag_im = acc_im_q[XW-1] ? XW'(-acc_im_q) : XW'(acc_im_q);
  assign n_half = XW'(n_q) << 14;
  assign u_re   = mag_re + n_half;
  assign u_im   = mag_im + n_half;
  assign v_re   = u_re[DW+14:15];
  assign v_im   = u_im[DW+14:15];

  // The re divider also produces 65536/N at block start.
  assign div_a_in = (state_q == rdft_pkg::S_SETUP) ? DW'(65536) : v_re;

  rdft_div u_div_re (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a_in),
    .divisor_i   (n_q),
    .done_o      (dre_done),
    .quotient_o  (quo_re),
    .remainder_o (rem_re)
  );

  rdft_div u_div_im (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (v_im),
    .divisor_i   (n_q),
    .done_o      (dim_done),
    .quotient_o  (quo_im),
    .remainder_o (rem_im)
  );

  // Restore the sign and clamp to 16 bits.
  always_comb begin
    if (acc_re_q[XW-1]) begin
      sat_re = (quo_re > DW'(32768)) ? 16'h8000 : SW'(DW'(0) - quo_re);
    end else begin
      sat_re = (quo_re > DW'(32767)) ? 16'h7FFF : quo_re[SW-1:0];
    end
    if (acc_im_q[XW-1]) begin
      sat_im = (quo_im > DW'(32768)) ? 16'h8000 : SW'(DW'(0) - quo_im);
    end else begin
      sat_im = (quo_im > DW'(32767)) ? 16'h7FFF : quo_im[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rdft_pkg::S_NORM_WAIT && dre_done && dim_done) begin
      re_q <= sat_re;
      im_q <= sat_im;
    end
  end

  rdft_polar u_polar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pol_start),
    .re_i    (re_q),
    .im_i    (im_q),
    .done_o  (pol_done),
    .mag_o   (pol_mag),
    .phase_o (pol_phase)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the word until taken; load the next bin on emit.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_bin_q  <= k_q;
      o_re_q   <= re_q;
      o_im_q   <= im_q;
      o_mag_q  <= pol_mag;
      o_ph_q   <= pol_phase;
      o_ovf_q  <= drop_q;
      o_last_q <= last_k;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = o_bin_q;
  assign real_part_o = o_re_q;
  assign imag_part_o = o_im_q;
  assign magnitude_o = o_mag_q;
  assign phase_o     = o_ph_q;
  assign overflow_o  = o_ovf_q;
  assign last_bin_o  = o_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(rdft_pkg::MaxPoints))
    else $error("sample count beyond capacity");

  a_run_points : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdft_pkg::S_MAC) |-> (n_q != '0 && n_q <= CW'(rdft_pkg::MaxPoints)))
    else $error("transform running with invalid point count");

  a_block_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_k) |=> (state_q == rdft_pkg::S_LOAD && cnt_q == '0 && !drop_q))
    else $error("store not emptied after final bin");

  a_dividers_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdft_pkg::S_NORM_WAIT && dre_done) |-> dim_done)
    else $error("real and imaginary dividers out of step");

endmodule

`default_nettype wire
